@@ rtl/joystick_gesture_event_decoder_core_assert.svh @@
// ---------------------------------------------------------------------------
// joystick gesture event decoder assertion macros
// implication and next-cycle checks with synchronous reset disable
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_GESTURE_EVENT_DECODER_CORE_ASSERT_SVH
`define JOYSTICK_GESTURE_EVENT_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define JGED_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JGED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/jged_pkg.sv @@
// ---------------------------------------------------------------------------
// jged_pkg
// shared constants, event codes and transfer types of the gesture decoder
// ---------------------------------------------------------------------------
package jged_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int PCT_W           = 7;
   localparam int LONG_W          = 16;
   localparam int CSR_DATA_W      = 16;
   localparam int TIME_W          = 32;
   localparam int CODE_W          = 4;
   localparam int DIR_W           = 3;
   localparam int PCT_SCALE       = 100;

   localparam logic [PCT_W-1:0]  DEADZONE_PCT_RST = 7'd10;
   localparam logic [LONG_W-1:0] LONG_PRESS_RST   = 16'd1000;

   // register indexes
   localparam logic CSR_DEADZONE   = 1'b0;
   localparam logic CSR_LONG_PRESS = 1'b1;

   // request kinds
   localparam logic REQ_POLL = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // directions
   localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

   // event codes
   localparam logic [CODE_W-1:0] EV_NONE         = 4'd0;
   localparam logic [CODE_W-1:0] EV_SELECT       = 4'd5;
   localparam logic [CODE_W-1:0] EV_BACK         = 4'd6;
   localparam logic [CODE_W-1:0] EV_GESTURE_BASE = 4'd6;
   localparam logic [CODE_W-1:0] EV_LAST         = 4'd10;

   typedef struct packed {
      logic              is_read;
      logic              pressed;
      logic [TIME_W-1:0] now;
      logic [DIR_W-1:0]  dir;
   } step_type;

   typedef struct packed {
      logic [CODE_W-1:0] event_code;
      logic              button_held;
   } result_type;

endpackage

@@ rtl/jged_dir.sv @@
// ---------------------------------------------------------------------------
// jged_dir
// centers both samples, applies the deadzone and picks the dominant axis
// ---------------------------------------------------------------------------
module jged_dir import jged_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0]       x_sample,
   input  logic [SAMPLE_BITS-1:0]       y_sample,
   input  logic [SAMPLE_BITS+PCT_W-1:0] dz_scaled,   // full scale times percent
   output logic [DIR_W-1:0]             dir
);

   localparam int PROD_W = SAMPLE_BITS + PCT_W;
   localparam logic [SAMPLE_BITS-1:0] HALF = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   logic                   x_neg;
   logic                   y_neg;
   logic [SAMPLE_BITS-1:0] ax;
   logic [SAMPLE_BITS-1:0] ay;
   logic [PROD_W-1:0]      ax_scaled;
   logic [PROD_W-1:0]      ay_scaled;

   assign x_neg = ~x_sample[SAMPLE_BITS-1];
   assign y_neg = ~y_sample[SAMPLE_BITS-1];
   assign ax = x_neg ? HALF - x_sample : {1'b0, x_sample[SAMPLE_BITS-2:0]};
   assign ay = y_neg ? HALF - y_sample : {1'b0, y_sample[SAMPLE_BITS-2:0]};

   // offset <= floor(full * pct / 100) is the same as 100 * offset <= full * pct
   assign ax_scaled = PROD_W'(ax) * PROD_W'(PCT_SCALE);
   assign ay_scaled = PROD_W'(ay) * PROD_W'(PCT_SCALE);

   always_comb begin
      if (ax_scaled <= dz_scaled && ay_scaled <= dz_scaled) begin
         dir = DIR_NONE;
      end else if (ax > ay) begin
         dir = x_neg ? DIR_LEFT : DIR_RIGHT;
      end else begin
         dir = y_neg ? DIR_UP : DIR_DOWN;
      end
   end

endmodule

@@ rtl/jged_state.sv @@
// ---------------------------------------------------------------------------
// jged_state
// press tracking, gesture capture and pending event register
// ---------------------------------------------------------------------------
module jged_state import jged_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  step_type          step,
   input  logic [LONG_W-1:0] long_press_ms,
   output result_type        result
);

`include "joystick_gesture_event_decoder_core_assert.svh"

   logic              button_was_down_ff, button_was_down_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              gesture_armed_ff, gesture_armed_in;
   logic [DIR_W-1:0]  gesture_dir_ff, gesture_dir_in;
   logic [CODE_W-1:0] pending_ff, pending_in;
   logic [TIME_W-1:0] held_for;
   logic              rise;
   logic              fall;

   assign rise     = step.pressed & ~button_was_down_ff;
   assign fall     = ~step.pressed & button_was_down_ff;
   assign held_for = step.now - press_start_ff;

   always_comb begin
      button_was_down_in = button_was_down_ff;
      press_start_in     = press_start_ff;
      gesture_armed_in   = gesture_armed_ff;
      gesture_dir_in     = gesture_dir_ff;
      pending_in         = pending_ff;
      if (step.is_read == REQ_READ) begin
         pending_in = EV_NONE;
      end else begin
         if (rise) begin
            press_start_in   = step.now;
            gesture_armed_in = 1'b1;
            gesture_dir_in   = DIR_NONE;
         end
         if (step.pressed && gesture_armed_in && step.dir != DIR_NONE) begin
            gesture_dir_in = step.dir;
         end
         if (fall) begin
            if (gesture_dir_ff != DIR_NONE) begin
               pending_in = EV_GESTURE_BASE + CODE_W'(gesture_dir_ff);
            end else if (held_for >= TIME_W'(long_press_ms)) begin
               pending_in = EV_BACK;
            end else begin
               pending_in = EV_SELECT;
            end
            gesture_armed_in = 1'b0;
            gesture_dir_in   = DIR_NONE;
         end
         button_was_down_in = step.pressed;
         if (!step.pressed && step.dir != DIR_NONE) begin
            pending_in = CODE_W'(step.dir);
         end
      end
   end

   always_comb begin
      if (step.is_read == REQ_READ) begin
         result.event_code  = pending_ff;
         result.button_held = button_was_down_ff;
      end else begin
         result.event_code  = EV_NONE;
         result.button_held = step.pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_was_down_ff <= 1'b0;
         press_start_ff     <= '0;
         gesture_armed_ff   <= 1'b0;
         gesture_dir_ff     <= DIR_NONE;
         pending_ff         <= EV_NONE;
      end else if (step_en) begin
         button_was_down_ff <= button_was_down_in;
         press_start_ff     <= press_start_in;
         gesture_armed_ff   <= gesture_armed_in;
         gesture_dir_ff     <= gesture_dir_in;
         pending_ff         <= pending_in;
      end
   end

   `JGED_ASSERT_IMPLY(a_armed_tracks_button, clock, reset, 1'b1,
      gesture_armed_ff == button_was_down_ff, "gesture armed out of step with button")
   `JGED_ASSERT_IMPLY(a_dir_only_while_held, clock, reset, !button_was_down_ff,
      gesture_dir_ff == DIR_NONE, "gesture direction kept while released")
   `JGED_ASSERT_IMPLY(a_pending_in_range, clock, reset, 1'b1,
      pending_ff <= EV_LAST, "pending event code out of range")
   `JGED_ASSERT_NEXT(a_read_clears, clock, reset, step_en && step.is_read == REQ_READ,
      pending_ff == EV_NONE, "pending event not cleared by read")

endmodule

@@ rtl/joystick_gesture_event_decoder_core.sv @@
// path: a taken request is held in the request register, its result in the response register
// throughput: one transaction per cycle while responses are taken, set by the
//   single-pass step between the request register and the response register
// reset: synchronous, active high; clears handshake and decoder state, deadzone to
//   ten percent and long press to 1000 ms
// ---------------------------------------------------------------------------
// joystick_gesture_event_decoder_core
// joystick poll and event read stream with gesture, select and back detection
// ---------------------------------------------------------------------------
module joystick_gesture_event_decoder_core import jged_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // x_sample, y_sample, button_down, time_ms, zero fill
   input  logic [((2*SAMPLE_BITS+TIME_W+1+7)/8)*8-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_code, button_held, zero fill
   output logic [7:0]            rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PROD_W  = SAMPLE_BITS + PCT_W;
   localparam int Y_LO    = SAMPLE_BITS;
   localparam int BTN_BIT = 2 * SAMPLE_BITS;
   localparam int TIME_LO = 2 * SAMPLE_BITS + 1;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
   localparam logic [PROD_W-1:0] DZ_SCALED_RST =
      PROD_W'(FULL_SCALE) * PROD_W'(DEADZONE_PCT_RST);

   logic                   req_vld_ff, req_vld_in;
   logic                   req_type_ff;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] y_ff;
   logic                   btn_ff;
   logic [TIME_W-1:0]      time_ff;
   logic                   rsp_vld_ff, rsp_vld_in;
   result_type             rsp_ff;
   logic [PROD_W-1:0]      dz_scaled_ff, dz_scaled_in;
   logic [LONG_W-1:0]      long_press_ff, long_press_in;
   logic                   advance;
   logic                   req_take;
   logic [DIR_W-1:0]       dir;
   step_type               step;
   result_type             result;

   assign advance    = req_vld_ff & (~rsp_vld_ff | rsp_tready);
   assign req_tready = ~req_vld_ff | advance;
   assign req_take   = req_tvalid & req_tready;
   assign req_vld_in = req_take | (req_vld_ff & ~advance);
   assign rsp_vld_in = advance | (rsp_vld_ff & ~rsp_tready);

   always_comb begin
      dz_scaled_in  = dz_scaled_ff;
      long_press_in = long_press_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEADZONE: dz_scaled_in = PROD_W'(FULL_SCALE) * PROD_W'(csr_wdata[PCT_W-1:0]);
            CSR_LONG_PRESS: long_press_in = csr_wdata[LONG_W-1:0];
            default: dz_scaled_in = dz_scaled_ff;
         endcase
      end
   end

   jged_dir #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dir (
      .x_sample  (x_ff),
      .y_sample  (y_ff),
      .dz_scaled (dz_scaled_ff),
      .dir       (dir)
   );

   assign step.is_read = req_type_ff;
   assign step.pressed = btn_ff;
   assign step.now     = time_ff;
   assign step.dir     = dir;

   jged_state u_state (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .step          (step),
      .long_press_ms (long_press_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         dz_scaled_ff  <= DZ_SCALED_RST;
         long_press_ff <= LONG_PRESS_RST;
      end else begin
         req_vld_ff    <= req_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         dz_scaled_ff  <= dz_scaled_in;
         long_press_ff <= long_press_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_type_ff <= req_tuser;
         x_ff        <= req_tdata[SAMPLE_BITS-1:0];
         y_ff        <= req_tdata[Y_LO +: SAMPLE_BITS];
         btn_ff      <= req_tdata[BTN_BIT];
         time_ff     <= req_tdata[TIME_LO +: TIME_W];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.button_held, rsp_ff.event_code};

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: joystick gesture event decoder regression
// Streams poll and read transactions into the decoder under several deadzone
// and long-press settings and with varied backpressure. A scoreboard
// predicts each response from its own decoder state and checks them in order.
// ---------------------------------------------------------------------------
module tb_top;
   import jged_pkg::*;

   localparam int SB       = SAMPLE_BITS_DEF;
   localparam int REQ_W    = ((2*SB+TIME_W+1+7)/8)*8;
   localparam int CENTER   = 1 << (SB-1);
   localparam int FULL     = (1 << SB) - 1;
   localparam int LIMIT    = 2000;
   localparam int PHASE_N  = 75;

   typedef struct {
      logic              is_read;
      logic [SB-1:0]     xs;
      logic [SB-1:0]     ys;
      logic              btn;
      logic [TIME_W-1:0] now;
   } joy_req_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   joy_req_type req_backlog[$];
   result_type  events_due[$];

   // decoder shadow state
   logic [PCT_W-1:0]  dz_pct    = DEADZONE_PCT_RST;
   logic [LONG_W-1:0] long_ms   = LONG_PRESS_RST;
   logic              was_down  = 1'b0;
   logic [TIME_W-1:0] press_t   = '0;
   logic              armed     = 1'b0;
   logic [DIR_W-1:0]  gest_dir  = DIR_NONE;
   logic [CODE_W-1:0] pend_code = EV_NONE;

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int sink_hold      = 0;
   int errors         = 0;
   int results_checked = 0;
   int events_read    = 0;
   int polls_queued   = 0;
   int reads_queued   = 0;
   int phase_items    = 0;
   int settings_run   = 1;
   int idle_cycles    = 0;
   logic req_accepted = 1'b0;

   joystick_gesture_event_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [DIR_W-1:0] stick_dir(logic [SB-1:0] xs, logic [SB-1:0] ys);
      int x;
      int y;
      int ax;
      int ay;
      int dz;
      x  = int'(xs) - CENTER;
      y  = int'(ys) - CENTER;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      dz = (FULL * int'(dz_pct)) / PCT_SCALE;
      if (ax <= dz && ay <= dz) return DIR_NONE;
      if (ax > ay) return (x < 0) ? DIR_LEFT : DIR_RIGHT;
      return (y < 0) ? DIR_UP : DIR_DOWN;
   endfunction

   function automatic result_type decode_request(logic kind, logic [SB-1:0] xs,
                                                 logic [SB-1:0] ys, logic btn,
                                                 logic [TIME_W-1:0] now);
      result_type r;
      logic [DIR_W-1:0] dir;
      logic [TIME_W-1:0] held_for;
      if (kind == REQ_READ) begin
         r.event_code  = pend_code;
         r.button_held = was_down;
         pend_code     = EV_NONE;
         return r;
      end
      dir = stick_dir(xs, ys);
      if (btn && !was_down) begin
         press_t  = now;
         armed    = 1'b1;
         gest_dir = DIR_NONE;
      end
      if (btn && armed && dir != DIR_NONE) gest_dir = dir;
      if (!btn && was_down) begin
         held_for = now - press_t;
         if (gest_dir != DIR_NONE) pend_code = EV_GESTURE_BASE + gest_dir;
         else if (held_for >= TIME_W'(long_ms)) pend_code = EV_BACK;
         else pend_code = EV_SELECT;
         armed    = 1'b0;
         gest_dir = DIR_NONE;
      end
      was_down = btn;
      if (!btn && dir != DIR_NONE) pend_code = CODE_W'(dir);
      r.event_code  = EV_NONE;
      r.button_held = btn;
      return r;
   endfunction

   function automatic void push_poll(int xs, int ys, logic btn, logic [TIME_W-1:0] now);
      joy_req_type it;
      it.is_read = REQ_POLL;
      it.xs      = SB'(xs);
      it.ys      = SB'(ys);
      it.btn     = btn;
      it.now     = now;
      req_backlog.push_back(it);
      polls_queued++;
      phase_items++;
   endfunction

   // ignored fields of a read carry noise
   function automatic void push_read();
      joy_req_type it;
      it.is_read = REQ_READ;
      it.xs      = SB'($urandom);
      it.ys      = SB'($urandom);
      it.btn     = 1'($urandom);
      it.now     = $urandom;
      req_backlog.push_back(it);
      reads_queued++;
      phase_items++;
   endfunction

   function automatic int pick_sample();
      int v;
      int j;
      int dz;
      dz = (FULL * int'(dz_pct)) / PCT_SCALE;
      case ($urandom_range(0, 5))
         0: v = CENTER;
         1: begin
            j = $urandom_range(0, 40);
            v = CENTER + j - 20;
         end
         2: begin
            j = dz + $urandom_range(0, 1);
            v = $urandom_range(0, 1) ? CENTER + j : CENTER - j;
         end
         3: v = $urandom_range(0, 1) ? FULL : 0;
         default: v = $urandom_range(0, FULL);
      endcase
      if (v < 0) v = 0;
      if (v > FULL) v = FULL;
      return v;
   endfunction

   // press, up to three held polls, release, usually followed by a read
   function automatic void queue_gesture();
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] dur;
      int n;
      t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
      push_poll($urandom_range(0, 2) ? CENTER : pick_sample(),
                $urandom_range(0, 2) ? CENTER : pick_sample(), 1'b1, t);
      n = $urandom_range(0, 3);
      repeat (n) begin
         t = t + $urandom_range(0, 400);
         if ($urandom_range(0, 1)) push_poll(CENTER, CENTER, 1'b1, t);
         else push_poll(pick_sample(), pick_sample(), 1'b1, t);
      end
      case ($urandom_range(0, 5))
         0: dur = TIME_W'(long_ms) - 1;
         1: dur = TIME_W'(long_ms);
         2: dur = TIME_W'(long_ms) + 1;
         3: dur = $urandom_range(0, 2000);
         4: dur = $urandom;
         default: dur = $urandom_range(0, 70000);
      endcase
      t = t + dur;
      if ($urandom_range(0, 3) != 0) push_poll(CENTER, CENTER, 1'b0, t);
      else push_poll(pick_sample(), pick_sample(), 1'b0, t);
      if ($urandom_range(0, 9) < 7) push_read();
   endfunction

   task automatic write_reg(logic idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DEADZONE) dz_pct = val[PCT_W-1:0];
      else long_ms = val[LONG_W-1:0];
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || events_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (4) @(posedge clock);
      #1;
   endtask

   task automatic run_phase(int pct, int lp, int sidle, int sstall, int hold);
      logic [CSR_DATA_W-1:0] w;
      w = $urandom;
      w[PCT_W-1:0] = PCT_W'(pct);
      write_reg(CSR_DEADZONE, w);
      write_reg(CSR_LONG_PRESS, CSR_DATA_W'(lp));
      settings_run++;
      @(posedge clock);
      src_idle_pct   = sidle;
      sink_stall_pct = sstall;
      sink_hold      = hold;
      phase_items    = 0;
      while (phase_items < PHASE_N) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: queue_gesture();
            6: push_poll(pick_sample(), pick_sample(), 1'($urandom), $urandom);
            7: push_poll(pick_sample(), pick_sample(), 1'b0, $urandom);
            default: push_read();
         endcase
      end
      wait_drained();
   endtask

   // request driver
   always @(negedge clock) begin
      joy_req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            it = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.is_read;
            req_tdata  <= REQ_W'({it.now, it.btn, it.ys, it.xs});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold  = sink_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      result_type want;
      logic [CODE_W-1:0] got_code;
      logic got_held;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got_code = rsp_tdata[CODE_W-1:0];
            got_held = rsp_tdata[CODE_W];
            if (events_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual code %0d held %0b",
                        $time, got_code, got_held);
               errors++;
            end else begin
               want = events_due.pop_front();
               results_checked++;
               if (got_code != EV_NONE) events_read++;
               if (got_code !== want.event_code) begin
                  $display("%0t: event_code mismatch, expected %0d actual %0d",
                           $time, want.event_code, got_code);
                  errors++;
               end
               if (got_held !== want.button_held) begin
                  $display("%0t: button_held mismatch, expected %0b actual %0b",
                           $time, want.button_held, got_held);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            events_due.push_back(decode_request(req_tuser, req_tdata[SB-1:0],
                                                req_tdata[2*SB-1:SB], req_tdata[2*SB],
                                                req_tdata[2*SB+TIME_W:2*SB+1]));
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles = idle_cycles + 1;
         if (idle_cycles >= LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      // directed part at reset settings: deadzone 409, long press 1000
      push_read();
      push_poll(CENTER, CENTER, 1'b0, 32'd0);
      push_poll(0, CENTER, 1'b0, 32'd1);
      push_read();
      push_poll(FULL, CENTER, 1'b0, 32'd2);
      push_poll(CENTER, 0, 1'b0, 32'd3);
      push_poll(CENTER, FULL, 1'b0, 32'd4);
      push_poll(0, 0, 1'b0, 32'd5);
      push_read();
      push_poll(CENTER + 409, CENTER, 1'b0, 32'd6);
      push_poll(CENTER + 410, CENTER, 1'b0, 32'd7);
      push_read();
      push_poll(CENTER, CENTER, 1'b1, 32'd100);
      push_poll(FULL, CENTER, 1'b1, 32'd150);
      push_poll(CENTER, CENTER, 1'b0, 32'd200);
      push_read();
      // press across the timestamp wrap
      push_poll(CENTER, CENTER, 1'b1, 32'hFFFF_FF00);
      push_poll(CENTER, CENTER, 1'b0, 32'h0000_0300);
      push_read();
      push_poll(CENTER, CENTER, 1'b1, 32'd500);
      push_poll(CENTER, CENTER, 1'b0, 32'd1499);
      push_read();
      // deflected release replaces the latched select
      push_poll(CENTER, CENTER, 1'b1, 32'd0);
      push_poll(0, CENTER, 1'b0, 32'd5);
      push_read();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      wait_drained();

      run_phase(0, 0, 0, 0, 0);
      run_phase(100, 65535, 62, 0, 0);
      run_phase(127, 1, 0, 62, 0);
      run_phase(50, 300, 35, 35, 0);
      run_phase(10, 1000, 0, 0, 300);
      run_phase($urandom_range(0, 100), $urandom_range(0, 65535), 35, 35, 0);
      run_phase($urandom_range(0, 127), $urandom_range(0, 3000), 62, 62, 0);

      repeat (8) @(posedge clock);
      #1;
      if (events_due.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, events_due.size());
         errors++;
      end
      $display("sent %0d polls and %0d reads under %0d register settings",
               polls_queued, reads_queued, settings_run);
      $display("checked %0d responses, %0d reads returned an event, %0d errors",
               results_checked, events_read, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
